### hw/rtl/tea_block_cipher_unit_assert.svh
// assertion macros shared by the tea block cipher rtl
`ifndef TEA_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define TEA_BLOCK_CIPHER_UNIT_ASSERT_SVH

// checked on every clock edge outside reset
`define TEA_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define TEA_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/tea_pkg.sv
`default_nettype none

package tea_pkg;

    localparam logic [31:0] TEA_DELTA   = 32'h9e37_79b9;
    localparam int unsigned TEA_ADDR_W  = 4;
    localparam int unsigned TEA_NUM_KEY = 4;

    typedef logic [1:0] t_key_idx;

    typedef enum logic [1:0] {
        KEY_WORD_ZERO  = 2'd0,
        KEY_WORD_ONE   = 2'd1,
        KEY_WORD_TWO   = 2'd2,
        KEY_WORD_THREE = 2'd3
    } t_key_reg;

    typedef struct packed {
        logic        mode;
        logic [31:0] first_word;
        logic [31:0] second_word;
    } t_tea_in;

    typedef struct packed {
        logic [31:0] out_first_word;
        logic [31:0] out_second_word;
    } t_tea_out;

    // round function of one half-round
    function automatic logic [31:0] tea_mix(
        input logic [31:0] v,
        input logic [31:0] sum,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

    // k * delta mod 2^32, only ever called on constants
    function automatic logic [31:0] tea_round_sum(input int unsigned k);
        logic [63:0] p;
        p = 64'(k) * 64'(TEA_DELTA);
        return p[31:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/tea_block_cipher_unit.sv
// an input beat passes the 2*ROUNDS half-round stage registers, then the output register
// throughput: one block per cycle while the skid register is free; one half-round per pipeline stage, 2*ROUNDS stages
// a stalled output parks one result in a skid register, then the whole pipe holds
// reset (synchronous, active low) empties the pipe, output and skid register
// and clears all four key words to zero
`default_nettype none
`include "tea_block_cipher_unit_assert.svh"

module tea_block_cipher_unit
    import tea_pkg::*;
#(
    parameter int unsigned ROUNDS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // block input
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_tea_in               i_in_data,
    // block output
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_tea_out                   o_out_data,
    // register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [TEA_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // two half-rounds per round, each gets a stage of its own
    localparam int unsigned NSTG = 2 * ROUNDS;

    // ------------------------------------------------------------------
    // key registers
    // ------------------------------------------------------------------
    logic [31:0] r_key [TEA_NUM_KEY];
    t_key_idx    w_widx;

    assign pready = 1'b1;
    assign w_widx = paddr[3:2];
    assign prdata = r_key[w_widx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[KEY_WORD_ZERO]  <= '0;
            r_key[KEY_WORD_ONE]   <= '0;
            r_key[KEY_WORD_TWO]   <= '0;
            r_key[KEY_WORD_THREE] <= '0;
        end else if (psel && penable && pwrite && pready) begin
            r_key[w_widx] <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // half-round pipeline
    // ------------------------------------------------------------------
    logic        r_v [NSTG];
    logic        r_m [NSTG];
    logic [31:0] r_a [NSTG];
    logic [31:0] r_b [NSTG];
    logic        n_v [NSTG];
    logic        n_m [NSTG];
    logic [31:0] n_a [NSTG];
    logic [31:0] n_b [NSTG];

    logic r_skid_vld;
    logic w_en;

    // the whole pipe moves whenever the skid register is free
    assign w_en       = !r_skid_vld;
    assign o_in_ready = w_en;

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        localparam int unsigned RND     = k / 2;
        localparam logic [31:0] SUM_ENC = tea_round_sum(RND + 1);
        localparam logic [31:0] SUM_DEC = tea_round_sum(ROUNDS - RND);
        localparam bit          HALF2   = (k % 2) == 1;

        logic        w_v;
        logic        w_m;
        logic [31:0] w_a;
        logic [31:0] w_b;
        logic [31:0] w_sum;
        logic        w_upd_a;
        logic [31:0] w_src;
        logic [31:0] w_ka;
        logic [31:0] w_kb;
        logic [31:0] w_mix;
        logic [31:0] w_dst;
        logic [31:0] w_res;

        if (k == 0) begin : g_head
            assign w_v = i_in_valid;
            assign w_m = i_in_data.mode;
            assign w_a = i_in_data.first_word;
            assign w_b = i_in_data.second_word;
        end else begin : g_body
            assign w_v = r_v[k-1];
            assign w_m = r_m[k-1];
            assign w_a = r_a[k-1];
            assign w_b = r_b[k-1];
        end

        // decryption runs the sum downwards and the half-rounds in swapped order
        assign w_sum   = w_m ? SUM_DEC : SUM_ENC;
        assign w_upd_a = (HALF2 == w_m);
        assign w_src   = w_upd_a ? w_b : w_a;
        assign w_ka    = w_upd_a ? r_key[KEY_WORD_ZERO] : r_key[KEY_WORD_TWO];
        assign w_kb    = w_upd_a ? r_key[KEY_WORD_ONE]  : r_key[KEY_WORD_THREE];
        assign w_mix   = tea_mix(w_src, w_sum, w_ka, w_kb);
        assign w_dst   = w_upd_a ? w_a : w_b;
        assign w_res   = w_m ? (w_dst - w_mix) : (w_dst + w_mix);

        assign n_v[k] = w_v;
        assign n_m[k] = w_m;
        assign n_a[k] = w_upd_a ? w_res : w_a;
        assign n_b[k] = w_upd_a ? w_b : w_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSTG; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_v <= n_v;
        end
    end

    // data registers carry no reset
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m <= n_m;
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    // ------------------------------------------------------------------
    // output register and skid register
    // ------------------------------------------------------------------
    t_tea_out r_out;
    t_tea_out n_out;
    logic     r_out_vld;
    logic     n_out_vld;
    t_tea_out r_skid;
    t_tea_out n_skid;
    logic     n_skid_vld;
    t_tea_out w_last;
    logic     w_arrive;
    logic     w_take;

    assign w_last.out_first_word  = r_a[NSTG-1];
    assign w_last.out_second_word = r_b[NSTG-1];
    assign w_arrive = w_en && r_v[NSTG-1];
    assign w_take   = r_out_vld && i_out_ready;

    always_comb begin
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        n_skid     = r_skid;
        n_skid_vld = r_skid_vld;
        if (w_take) begin
            if (r_skid_vld) begin
                // parked beat moves up; the pipe was held so nothing arrives
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end else if (w_arrive) begin
                n_out = w_last;
            end else begin
                n_out_vld = 1'b0;
            end
        end else if (w_arrive) begin
            if (!r_out_vld) begin
                n_out     = w_last;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = w_last;
                n_skid_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `TEA_ASSERT_RUN(a_skid_needs_out, r_skid_vld |-> r_out_vld, "skid full while output empty")
    `TEA_ASSERT_RUN(a_skid_fill_cause, $rose(r_skid_vld) |-> $past(r_out_vld && !i_out_ready),
        "skid filled without a stalled output")
    `TEA_ASSERT_RUN(a_pipe_holds, !w_en |=> $stable(r_v[NSTG-1]) && $stable(r_a[NSTG-1]),
        "pipe moved while held")
    `TEA_ASSERT_ALL(a_reset_empty, !i_rst_n |=> !r_out_vld && !r_skid_vld && !r_v[0],
        "pipe not empty after reset")

endmodule

`default_nettype wire

### tb/tb_tea_block_cipher_unit.sv
module tb_tea_block_cipher_unit
    import tea_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CIPHER_ROUNDS = 32;
    // round sum that decryption starts from, ROUNDS * delta mod 2^32
    localparam logic [31:0] DECRYPT_START = 32'(CIPHER_ROUNDS * TEA_DELTA);
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;
    // receiver holds off once, after this many output beats, for this many cycles
    localparam int unsigned HOLD_AT_BEAT = 160;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned RANDOM_PER_PHASE = 120;

    // clock, reset and every block input start at known values
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_tea_in               i_in_data   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [TEA_ADDR_W-1:0] paddr       = '0;
    logic [31:0]           pwdata      = '0;
    wire logic             o_in_ready;
    wire logic             o_out_valid;
    t_tea_out              o_out_data;
    wire logic [31:0]      prdata;
    wire logic             pready;

    // blocks waiting to be offered, and ciphertext/plaintext still owed by the block
    t_tea_in     pending_blocks[$];
    t_tea_out    expected_blocks[$];
    // our own copy of the four key words
    logic [31:0] key_words [TEA_NUM_KEY];
    int unsigned mismatches = 0;

    tea_block_cipher_unit #(
        .ROUNDS(CIPHER_ROUNDS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // one half-round of the feistel network
    function automatic logic [31:0] feistel_f(
        input logic [31:0] v,
        input logic [31:0] sum,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        logic [31:0] shl_term;
        logic [31:0] shr_term;
        shl_term = (v << 4) + ka;
        shr_term = (v >> 5) + kb;
        return shl_term ^ (v + sum) ^ shr_term;
    endfunction

    // full CIPHER_ROUNDS-round tea pass under the current key words
    function automatic t_tea_out tea_cipher(input t_tea_in blk);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] sum;
        t_tea_out    res;
        a = blk.first_word;
        b = blk.second_word;
        if (blk.mode == MODE_ENCRYPT) begin
            sum = '0;
            for (int r = 0; r < CIPHER_ROUNDS; r++) begin
                sum = sum + TEA_DELTA;
                a = a + feistel_f(b, sum, key_words[KEY_WORD_ZERO], key_words[KEY_WORD_ONE]);
                b = b + feistel_f(a, sum, key_words[KEY_WORD_TWO], key_words[KEY_WORD_THREE]);
            end
        end else begin
            // decryption walks the round sums back down from the top
            sum = DECRYPT_START;
            for (int r = 0; r < CIPHER_ROUNDS; r++) begin
                b = b - feistel_f(a, sum, key_words[KEY_WORD_TWO], key_words[KEY_WORD_THREE]);
                a = a - feistel_f(b, sum, key_words[KEY_WORD_ZERO], key_words[KEY_WORD_ONE]);
                sum = sum - TEA_DELTA;
            end
        end
        res.out_first_word  = a;
        res.out_second_word = b;
        return res;
    endfunction

    task automatic queue_block(input logic m, input logic [31:0] a, input logic [31:0] b);
        pending_blocks.push_back(t_tea_in'{mode: m, first_word: a, second_word: b});
    endtask

    // queue a block and then the block that undoes it
    task automatic queue_round_trip(input logic m, input logic [31:0] a, input logic [31:0] b);
        t_tea_out res;
        res = tea_cipher(t_tea_in'{mode: m, first_word: a, second_word: b});
        queue_block(m, a, b);
        queue_block(m == MODE_ENCRYPT ? MODE_DECRYPT : MODE_ENCRYPT,
                    res.out_first_word, res.out_second_word);
    endtask

    // all-zero, all-one and single-bit words in both modes, alternating words in encrypt mode, two round trips
    task automatic queue_corner_blocks();
        queue_block(MODE_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        queue_block(MODE_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        queue_block(MODE_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
        queue_block(MODE_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
        queue_block(MODE_ENCRYPT, 32'h0000_0000, 32'hffff_ffff);
        queue_block(MODE_DECRYPT, 32'hffff_ffff, 32'h0000_0000);
        queue_block(MODE_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        queue_block(MODE_DECRYPT, 32'h0000_0001, 32'h8000_0000);
        queue_block(MODE_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555);
        queue_round_trip(MODE_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
        queue_round_trip(MODE_DECRYPT, 32'hfedc_ba98, 32'h7654_3210);
    endtask

    function automatic logic [31:0] pick_edge_word();
        logic [31:0] one_hot;
        one_hot = 32'h1 << $urandom_range(0, 31);
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return one_hot;
            default: return ~one_hot;
        endcase
    endfunction

    task automatic queue_random_blocks(input int unsigned count);
        int unsigned queued;
        int unsigned kind;
        logic [31:0] a;
        logic [31:0] b;
        logic        m;
        queued = 0;
        while (queued < count) begin
            kind = $urandom_range(0, 9);
            a    = $urandom;
            b    = $urandom;
            m    = ($urandom_range(0, 1) == 0) ? MODE_ENCRYPT : MODE_DECRYPT;
            if (kind == 9) begin
                a = pick_edge_word();
                b = pick_edge_word();
            end
            if (kind >= 7 && kind <= 8) begin
                queue_round_trip(m, a, b);
                queued += 2;
            end else begin
                queue_block(m, a, b);
                queued++;
            end
        end
    endtask

    // apb write: setup cycle, then access until pready
    task automatic write_key(input t_key_reg idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TEA_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        key_words[idx] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_keys(
        input logic [31:0] k0,
        input logic [31:0] k1,
        input logic [31:0] k2,
        input logic [31:0] k3
    );
        write_key(KEY_WORD_ZERO, k0);
        write_key(KEY_WORD_ONE, k1);
        write_key(KEY_WORD_TWO, k2);
        write_key(KEY_WORD_THREE, k3);
    endtask

    // block is idle once nothing is queued, offered or owed
    task automatic wait_for_drain();
        while (pending_blocks.size() != 0 || i_in_valid || expected_blocks.size() != 0)
            @(posedge i_clk);
    endtask

    // input side: bursts of random length with random gaps between them
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // an accepted beat is predicted with the keys in force now
            if (i_in_valid && o_in_ready) begin
                expected_blocks.push_back(tea_cipher(i_in_data));
                void'(pending_blocks.pop_front());
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_blocks.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_blocks[0];
                    if (burst_left <= 1) begin
                        // roughly a third of the bursts run straight into the next
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: rotating stall pattern, swapped each time pattern_age wraps, plus one long hold-off
    logic [7:0]  stall_pattern = 8'hff;
    int unsigned pattern_age   = 0;
    int unsigned hold_left     = 0;
    int unsigned beats_taken   = 0;
    logic        hold_done     = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                beats_taken++;
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && beats_taken >= HOLD_AT_BEAT) begin
                // sender keeps going, so the pipe fills and stalls the input
                hold_done    = 1'b1;
                hold_left    = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                if (pattern_age == 0) begin
                    case ($urandom_range(0, 3))
                        0: stall_pattern = 8'hff;
                        1: stall_pattern = 8'h11;
                        default: stall_pattern = 8'($urandom) | 8'h01;
                    endcase
                end else begin
                    stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
                end
                pattern_age  = (pattern_age + 1) % 64;
                i_out_ready <= stall_pattern[0];
            end
        end
    end

    // result checker: each output beat against the oldest owed block
    always @(posedge i_clk) begin : result_check
        t_tea_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_blocks.size() == 0) begin
                flag_mismatch("output beat with no block owed");
            end else begin
                want = expected_blocks.pop_front();
                if (o_out_data.out_first_word !== want.out_first_word)
                    flag_mismatch($sformatf("out_first_word got %h want %h",
                                            o_out_data.out_first_word, want.out_first_word));
                if (o_out_data.out_second_word !== want.out_second_word)
                    flag_mismatch($sformatf("out_second_word got %h want %h",
                                            o_out_data.out_second_word, want.out_second_word));
            end
        end
    end

    // stimulus: key settings in phases, keys only change while the pipe is empty
    initial begin
        foreach (key_words[k])
            key_words[k] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // keys straight out of reset, all zero
        queue_corner_blocks();
        queue_random_blocks(RANDOM_PER_PHASE);
        wait_for_drain();

        // all key bits set
        load_keys(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        queue_corner_blocks();
        queue_random_blocks(RANDOM_PER_PHASE);
        wait_for_drain();

        load_keys($urandom, $urandom, $urandom, $urandom);
        queue_random_blocks(RANDOM_PER_PHASE);
        wait_for_drain();

        // mixed extremes so each key word is told apart from the others
        load_keys(32'h0000_0000, 32'hffff_ffff, 32'haaaa_aaaa, 32'h5555_5555);
        queue_random_blocks(RANDOM_PER_PHASE);
        wait_for_drain();

        load_keys($urandom, $urandom, $urandom, $urandom);
        queue_random_blocks(RANDOM_PER_PHASE);
        wait_for_drain();

        // room for any stray beat beyond the pipe depth
        repeat (2 * CIPHER_ROUNDS + 5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
